@@ rtl/core/pi_controller_clamped_macros.svh @@
// Assertion macros for the clamped PI controller.
// Included by modules that check their own logic; expects clk and rst_n in scope.
`ifndef PI_CONTROLLER_CLAMPED_MACROS_SVH
`define PI_CONTROLLER_CLAMPED_MACROS_SVH

// Same-cycle implication, disabled during reset
`define PIC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define PIC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/pic_pkg.sv @@
// Shared widths, codes, state types and interface structs of the clamped PI controller.
// No dependencies; used by pic_scale_unit and pi_controller_clamped.
`default_nettype none

package pic_pkg;

  // Field and register widths
  localparam int DataW    = 16;
  localparam int GainW    = 8;
  localparam int LimitW   = 15;
  localparam int IntegW   = 32;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 15;

  // Scale unit: product magnitude, scaled result and chunked divide sizes
  localparam int ProdW      = 40;
  localparam int ScaleW     = 34;
  localparam int ChunkW     = 20;
  localparam int NumChunks  = ProdW / ChunkW;
  localparam int RemW       = 7;
  localparam int PartW      = RemW + ChunkW;
  localparam int RecipW     = 28;
  localparam int RecipShift = 34;
  localparam int RecipProdW = PartW + RecipW;
  localparam int DivCntW    = 1;
  localparam int TermW      = 18;
  localparam int AccW       = IntegW + 3;
  localparam int CapW       = LimitW + 2;

  localparam logic [RemW-1:0] Divisor = RemW'(100);
  // Reciprocal of the divisor: ceil(2^RecipShift / 100)
  localparam logic [RecipW-1:0] Recip = RecipW'(171798692);

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_PROP_GAIN    = 2'd0,
    REG_INTEG_GAIN   = 2'd1,
    REG_TIME_STEP    = 2'd2,
    REG_OUTPUT_LIMIT = 2'd3
  } cfg_reg_t;

  // Scale unit sequencer
  typedef enum logic [2:0] {
    SC_IDLE,
    SC_MUL,
    SC_DIV,
    SC_REM,
    SC_FIN
  } scale_state_t;

  // Controller sequencer
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INTEG,
    ST_WAIT_INTEG,
    ST_PROP,
    ST_WAIT_PROP,
    ST_GAIN,
    ST_WAIT_GAIN,
    ST_OUT
  } ctl_state_t;

  // Request into the scale unit: operand * gain / 100
  typedef struct packed {
    logic                     start;
    logic signed [IntegW-1:0] operand;
    logic [GainW-1:0]         gain;
  } scale_req_t;

  // Response from the scale unit
  typedef struct packed {
    logic                     busy;
    logic                     done;
    logic signed [ScaleW-1:0] result;
  } scale_rsp_t;

endpackage

`default_nettype wire

@@ rtl/core/pic_scale_unit.sv @@
// Shared scale unit: signed operand times unsigned gain, divided by 100 toward zero.
// A multiply step, then the magnitude is divided in two 20-bit chunks by reciprocal
// multiplication, a digit step and a remainder step per chunk. Uses pic_pkg.
`default_nettype none

module pic_scale_unit (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire pic_pkg::scale_req_t req,
  output pic_pkg::scale_rsp_t      rsp
);

  pic_pkg::scale_state_t state_r, state_nxt;

  logic signed [pic_pkg::IntegW-1:0]  opnd_r, opnd_nxt;
  logic [pic_pkg::GainW-1:0]          gain_r, gain_nxt;
  logic                               neg_r, neg_nxt;
  logic [pic_pkg::ProdW-1:0]          quo_r, quo_nxt;
  logic [pic_pkg::RemW-1:0]           rem_r, rem_nxt;
  logic [pic_pkg::PartW-1:0]          part_r, part_nxt;
  logic [pic_pkg::ChunkW-1:0]         digit_r, digit_nxt;
  logic [pic_pkg::DivCntW-1:0]        cnt_r, cnt_nxt;
  logic signed [pic_pkg::ScaleW-1:0]  result_r, result_nxt;
  logic                               done_r, done_nxt;

  logic signed [pic_pkg::IntegW+pic_pkg::GainW:0] prod;
  logic [pic_pkg::ProdW-1:0]          prod_mag;
  logic [pic_pkg::PartW-1:0]          part;
  logic [pic_pkg::RecipProdW-1:0]     recip_prod;
  logic [pic_pkg::PartW-1:0]          rem_full;
  logic [pic_pkg::ScaleW-1:0]         quo_trim;

  // Multiply: gain is zero-extended so the product stays signed
  assign prod     = opnd_r * $signed({1'b0, gain_r});
  assign prod_mag = prod[pic_pkg::IntegW+pic_pkg::GainW] ?
                    pic_pkg::ProdW'(-prod) : pic_pkg::ProdW'(prod);

  // Partial dividend: remainder so far followed by the next chunk of the magnitude
  assign part       = {rem_r, quo_r[pic_pkg::ProdW-1 -: pic_pkg::ChunkW]};
  // Quotient digit by reciprocal multiply; exact for partial dividends below 2^30
  assign recip_prod = pic_pkg::RecipProdW'(part) * pic_pkg::RecipProdW'(pic_pkg::Recip);
  // Remainder left by the registered digit
  assign rem_full   = part_r - pic_pkg::PartW'(digit_r) * pic_pkg::PartW'(pic_pkg::Divisor);
  assign quo_trim   = {1'b0, quo_r[pic_pkg::ScaleW-2:0]};

  // Sequencer and datapath next values
  always_comb begin
    state_nxt  = state_r;
    opnd_nxt   = opnd_r;
    gain_nxt   = gain_r;
    neg_nxt    = neg_r;
    quo_nxt    = quo_r;
    rem_nxt    = rem_r;
    part_nxt   = part_r;
    digit_nxt  = digit_r;
    cnt_nxt    = cnt_r;
    result_nxt = result_r;
    done_nxt   = 1'b0;
    unique case (state_r)
      pic_pkg::SC_IDLE: begin
        if (req.start) begin
          opnd_nxt  = req.operand;
          gain_nxt  = req.gain;
          state_nxt = pic_pkg::SC_MUL;
        end
      end
      pic_pkg::SC_MUL: begin
        neg_nxt   = prod[pic_pkg::IntegW+pic_pkg::GainW];
        quo_nxt   = prod_mag;
        rem_nxt   = '0;
        cnt_nxt   = pic_pkg::DivCntW'(pic_pkg::NumChunks - 1);
        state_nxt = pic_pkg::SC_DIV;
      end
      pic_pkg::SC_DIV: begin
        part_nxt  = part;
        digit_nxt = recip_prod[pic_pkg::RecipShift +: pic_pkg::ChunkW];
        state_nxt = pic_pkg::SC_REM;
      end
      pic_pkg::SC_REM: begin
        // Shift the digit into the quotient, keep the remainder for the next chunk
        rem_nxt = pic_pkg::RemW'(rem_full);
        quo_nxt = {quo_r[pic_pkg::ProdW-pic_pkg::ChunkW-1:0], digit_r};
        if (cnt_r == '0) begin
          state_nxt = pic_pkg::SC_FIN;
        end else begin
          cnt_nxt   = cnt_r - 1'b1;
          state_nxt = pic_pkg::SC_DIV;
        end
      end
      pic_pkg::SC_FIN: begin
        // Restore the sign: truncation toward zero falls out of dividing the magnitude
        result_nxt = neg_r ? -$signed(quo_trim) : $signed(quo_trim);
        done_nxt   = 1'b1;
        state_nxt  = pic_pkg::SC_IDLE;
      end
      default: begin
        state_nxt = pic_pkg::SC_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pic_pkg::SC_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    opnd_r   <= opnd_nxt;
    gain_r   <= gain_nxt;
    neg_r    <= neg_nxt;
    quo_r    <= quo_nxt;
    rem_r    <= rem_nxt;
    part_r   <= part_nxt;
    digit_r  <= digit_nxt;
    cnt_r    <= cnt_nxt;
    result_r <= result_nxt;
  end

  assign rsp.busy   = (state_r != pic_pkg::SC_IDLE);
  assign rsp.done   = done_r;
  assign rsp.result = result_r;

endmodule

`default_nettype wire

@@ rtl/core/pi_controller_clamped.sv @@
// Clamped PI controller, top level: configuration registers, integral state and sequencer.
// Depends on pic_pkg, pic_scale_unit and pi_controller_clamped_macros.svh.
//
// Each input transaction carries a target and a measured value and yields one drive
// transaction. The error is saturated to 16 bits; the integral gains error*time_step/100,
// is capped at 3*output_limit and saturates at the 32-bit minimum; the drive is
// prop_gain*error/100 + integ_gain*integral/100, capped at output_limit and saturated at
// -32768, all divisions truncating toward zero. The three scaled products go one after
// another through a single multiply-and-divide-by-100 unit that divides the 40-bit
// magnitude in two 20-bit chunks by reciprocal multiplication. Each product passes through
// a start, a multiply, a digit and a remainder step per chunk, a sign restore and a
// response, and the drive then passes through the output state before the next acceptance.
// in_ready is high only while the sequencer is idle; a finished drive waits in
// the output register and the next input may be taken meanwhile, but a drive that finds
// the output register still full stalls the sequencer until out_ready. Any configuration
// write clears the integral; write only while the block is idle.
`default_nettype none

module pi_controller_clamped (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // Configuration write port
  input  wire logic                                cfg_wr_en,
  input  wire logic [pic_pkg::CfgIdxW-1:0]         cfg_index,
  input  wire logic [pic_pkg::CfgDataW-1:0]        cfg_data,
  // Input channel
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic signed [pic_pkg::DataW-1:0]    in_target_value,
  input  wire logic signed [pic_pkg::DataW-1:0]    in_measured_value,
  // Result channel
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [pic_pkg::DataW-1:0]         out_drive
);

  localparam logic signed [pic_pkg::AccW-1:0] AccMin =
    {{(pic_pkg::AccW - pic_pkg::IntegW + 1){1'b1}}, {(pic_pkg::IntegW - 1){1'b0}}};
  localparam logic signed [pic_pkg::AccW-1:0] DriveMin =
    {{(pic_pkg::AccW - pic_pkg::DataW + 1){1'b1}}, {(pic_pkg::DataW - 1){1'b0}}};
  localparam logic signed [pic_pkg::DataW:0] ErrMax =
    {2'b00, {(pic_pkg::DataW - 1){1'b1}}};
  localparam logic signed [pic_pkg::DataW:0] ErrMin =
    {2'b11, {(pic_pkg::DataW - 1){1'b0}}};

  pic_pkg::ctl_state_t state_r, state_nxt;

  logic [pic_pkg::GainW-1:0]          prop_gain_r, prop_gain_nxt;
  logic [pic_pkg::GainW-1:0]          integ_gain_r, integ_gain_nxt;
  logic [pic_pkg::GainW-1:0]          time_step_r, time_step_nxt;
  logic [pic_pkg::LimitW-1:0]         output_limit_r, output_limit_nxt;
  logic signed [pic_pkg::IntegW-1:0]  integral_r, integral_nxt;
  logic signed [pic_pkg::DataW-1:0]   err_r, err_nxt;
  logic signed [pic_pkg::TermW-1:0]   term_p_r, term_p_nxt;
  logic signed [pic_pkg::DataW-1:0]   drive_r, drive_nxt;
  logic signed [pic_pkg::DataW-1:0]   out_drive_r, out_drive_nxt;
  logic                               out_valid_r, out_valid_nxt;

  pic_pkg::scale_req_t scale_req;
  pic_pkg::scale_rsp_t scale_rsp;

  logic signed [pic_pkg::DataW:0]     diff;
  logic signed [pic_pkg::DataW-1:0]   err_sat;
  logic [pic_pkg::CapW-1:0]           cap;
  logic signed [pic_pkg::AccW-1:0]    cap_acc;
  logic signed [pic_pkg::AccW-1:0]    acc;
  logic signed [pic_pkg::AccW-1:0]    acc_sat;
  logic signed [pic_pkg::AccW-1:0]    limit_acc;
  logic signed [pic_pkg::AccW-1:0]    sum;
  logic signed [pic_pkg::AccW-1:0]    sum_sat;
  logic signed [pic_pkg::IntegW-1:0]  cap_ext;
  logic signed [pic_pkg::DataW-1:0]   limit_ext;

  // Error, saturated to the field range
  assign diff    = {in_target_value[pic_pkg::DataW-1], in_target_value}
                 - {in_measured_value[pic_pkg::DataW-1], in_measured_value};
  assign err_sat = (diff > ErrMax) ? pic_pkg::DataW'(ErrMax) :
                   (diff < ErrMin) ? pic_pkg::DataW'(ErrMin) : pic_pkg::DataW'(diff);

  // Integral cap is three times the output limit
  assign cap       = pic_pkg::CapW'({output_limit_r, 1'b0}) + pic_pkg::CapW'(output_limit_r);
  assign cap_acc   = $signed(pic_pkg::AccW'(cap));
  assign limit_acc = $signed(pic_pkg::AccW'(output_limit_r));
  assign cap_ext   = $signed(pic_pkg::IntegW'(cap));
  assign limit_ext = $signed({1'b0, output_limit_r});

  // Integral update with cap above and 32-bit floor below
  assign acc     = pic_pkg::AccW'(integral_r) + pic_pkg::AccW'(scale_rsp.result);
  assign acc_sat = (acc > cap_acc) ? cap_acc : (acc < AccMin) ? AccMin : acc;

  // Drive sum with cap above and 16-bit floor below
  assign sum     = pic_pkg::AccW'(term_p_r) + pic_pkg::AccW'(scale_rsp.result);
  assign sum_sat = (sum > limit_acc) ? limit_acc : (sum < DriveMin) ? DriveMin : sum;

  // Operand and gain for the shared scale unit
  always_comb begin
    scale_req.start   = 1'b0;
    scale_req.operand = pic_pkg::IntegW'(err_r);
    scale_req.gain    = time_step_r;
    case (state_r)
      pic_pkg::ST_INTEG: begin
        scale_req.start = 1'b1;
      end
      pic_pkg::ST_PROP: begin
        scale_req.start = 1'b1;
        scale_req.gain  = prop_gain_r;
      end
      pic_pkg::ST_GAIN: begin
        scale_req.start   = 1'b1;
        scale_req.operand = integral_r;
        scale_req.gain    = integ_gain_r;
      end
      default: begin
      end
    endcase
  end

  pic_scale_unit u_scale (
    .clk (clk),
    .rst_n (rst_n),
    .req (scale_req),
    .rsp (scale_rsp)
  );

  // Sequencer, configuration and datapath next values
  always_comb begin
    state_nxt        = state_r;
    prop_gain_nxt    = prop_gain_r;
    integ_gain_nxt   = integ_gain_r;
    time_step_nxt    = time_step_r;
    output_limit_nxt = output_limit_r;
    integral_nxt     = integral_r;
    err_nxt          = err_r;
    term_p_nxt       = term_p_r;
    drive_nxt        = drive_r;
    out_drive_nxt    = out_drive_r;
    out_valid_nxt    = out_valid_r;

    // Drop the result once taken
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      pic_pkg::ST_IDLE: begin
        if (in_valid) begin
          err_nxt   = err_sat;
          state_nxt = pic_pkg::ST_INTEG;
        end
      end
      pic_pkg::ST_INTEG: begin
        state_nxt = pic_pkg::ST_WAIT_INTEG;
      end
      pic_pkg::ST_WAIT_INTEG: begin
        if (scale_rsp.done) begin
          integral_nxt = pic_pkg::IntegW'(acc_sat);
          state_nxt    = pic_pkg::ST_PROP;
        end
      end
      pic_pkg::ST_PROP: begin
        state_nxt = pic_pkg::ST_WAIT_PROP;
      end
      pic_pkg::ST_WAIT_PROP: begin
        if (scale_rsp.done) begin
          term_p_nxt = pic_pkg::TermW'(scale_rsp.result);
          state_nxt  = pic_pkg::ST_GAIN;
        end
      end
      pic_pkg::ST_GAIN: begin
        state_nxt = pic_pkg::ST_WAIT_GAIN;
      end
      pic_pkg::ST_WAIT_GAIN: begin
        if (scale_rsp.done) begin
          drive_nxt = pic_pkg::DataW'(sum_sat);
          state_nxt = pic_pkg::ST_OUT;
        end
      end
      pic_pkg::ST_OUT: begin
        // Hold until the output register is free
        if (!out_valid_r || out_ready) begin
          out_drive_nxt = drive_r;
          out_valid_nxt = 1'b1;
          state_nxt     = pic_pkg::ST_IDLE;
        end
      end
    endcase

    // Store a configuration register and clear the integral
    if (cfg_wr_en) begin
      integral_nxt = '0;
      unique case (pic_pkg::cfg_reg_t'(cfg_index))
        pic_pkg::REG_PROP_GAIN:    prop_gain_nxt    = pic_pkg::GainW'(cfg_data);
        pic_pkg::REG_INTEG_GAIN:   integ_gain_nxt   = pic_pkg::GainW'(cfg_data);
        pic_pkg::REG_TIME_STEP:    time_step_nxt    = pic_pkg::GainW'(cfg_data);
        pic_pkg::REG_OUTPUT_LIMIT: output_limit_nxt = pic_pkg::LimitW'(cfg_data);
      endcase
    end
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= pic_pkg::ST_IDLE;
      prop_gain_r    <= '0;
      integ_gain_r   <= '0;
      time_step_r    <= '0;
      output_limit_r <= '0;
      integral_r     <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      prop_gain_r    <= prop_gain_nxt;
      integ_gain_r   <= integ_gain_nxt;
      time_step_r    <= time_step_nxt;
      output_limit_r <= output_limit_nxt;
      integral_r     <= integral_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    err_r       <= err_nxt;
    term_p_r    <= term_p_nxt;
    drive_r     <= drive_nxt;
    out_drive_r <= out_drive_nxt;
  end

  assign in_ready  = (state_r == pic_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_drive = out_drive_r;

  // Checks
  `include "pi_controller_clamped_macros.svh"

  `PIC_ASSERT_IMPL(a_integ_under_cap, 1'b1, integral_r <= cap_ext, "integral above cap")
  `PIC_ASSERT_IMPL(a_drive_under_limit, out_valid, out_drive <= limit_ext, "drive above limit")
  `PIC_ASSERT_IMPL(a_scale_start_idle, scale_req.start, !scale_rsp.busy, "scale unit restarted")
  `PIC_ASSERT_NEXT(a_accept_starts, in_valid && in_ready, state_r == pic_pkg::ST_INTEG, "no start")

endmodule

`default_nettype wire
